FILE: hw/rtl/aes_round_sub_shift_mix_macros.svh
// assertion helpers for the aes round block
`ifndef AES_ROUND_SUB_SHIFT_MIX_MACROS_SVH
`define AES_ROUND_SUB_SHIFT_MIX_MACROS_SVH

// implication checked on every clock edge outside reset
`define ARSM_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ARSM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/arsm_pkg.sv
`default_nettype none
package arsm_pkg;

    localparam int unsigned ColWidth = 32;
    localparam int unsigned NumCols  = 4;
    localparam logic [7:0]  GfPoly   = 8'h1b;

    typedef logic [7:0]          t_byte;
    typedef logic [ColWidth-1:0] t_col;

    typedef struct packed {
        t_col col_3;
        t_col col_2;
        t_col col_1;
        t_col col_0;
    } t_state;

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic t_byte gf_double(input t_byte v);
        t_byte d;
        d = {v[6:0], 1'b0};
        if (v[7]) begin
            d = d ^ GfPoly;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/arsm_if.sv
`default_nettype none
interface arsm_if;
    import arsm_pkg::*;
    logic   valid;
    logic   ready;
    t_state data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/arsm_column_lane.sv
`default_nettype none
// one column: s-box on four bytes already gathered by shiftrows, then mixcolumns
module arsm_column_lane (
    input  wire arsm_pkg::t_col i_col,
    output arsm_pkg::t_col      o_col
);
    import arsm_pkg::*;

    t_byte a [4];
    t_byte d [4];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            a[r] = SBOX[i_col[8*r +: 8]];
            d[r] = gf_double(a[r]);
        end
        o_col[7:0]   = d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3];
        o_col[15:8]  = a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3];
        o_col[23:16] = a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3];
        o_col[31:24] = d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/aes_round_sub_shift_mix.sv
`default_nettype none
// AES round without key addition: SubBytes, ShiftRows and MixColumns on one
// 128-bit state per beat. Fully pipelined: a new state is accepted every
// cycle unless a held result is stalled, and each result appears in the
// cycle after its input beat is taken (a single output register). Four
// column lanes work in parallel; since ShiftRows only moves bytes, it is
// done as wiring ahead of the lanes and the lane outputs merge into the
// output register. Stalls propagate straight back: ready follows the output side.
`include "aes_round_sub_shift_mix_macros.svh"
module aes_round_sub_shift_mix (
    input wire   i_clk,
    input wire   i_rst_n,
    arsm_if.sink   i_in,
    arsm_if.source o_out
);
    import arsm_pkg::*;

    t_col   lane_in  [NumCols];
    t_col   lane_out [NumCols];
    t_col   in_cols  [NumCols];
    t_state n_data;
    t_state r_data;
    logic   r_valid;
    logic   in_beat;

    assign in_cols[0] = i_in.data.col_0;
    assign in_cols[1] = i_in.data.col_1;
    assign in_cols[2] = i_in.data.col_2;
    assign in_cols[3] = i_in.data.col_3;

    // shiftrows: row r of column c comes from column c+r
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                lane_in[c][8*r +: 8] = in_cols[(c + r) % 4][8*r +: 8];
            end
        end
    end

    for (genvar g = 0; g < NumCols; g++) begin : g_lane
        arsm_column_lane u_lane (.i_col(lane_in[g]), .o_col(lane_out[g]));
    end

    // merge lanes into the output state
    assign n_data = '{col_3: lane_out[3], col_2: lane_out[2],
                      col_1: lane_out[1], col_0: lane_out[0]};

    assign i_in.ready = !r_valid || o_out.ready;
    assign in_beat    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_data <= n_data;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_data;

    // a stalled result must hold until taken
    `ARSM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_valid && !o_out.ready, r_valid && $stable(r_data))
    // an accepted beat always produces a result next cycle
    `ARSM_ASSERT_NEXT(a_load, i_clk, i_rst_n, in_beat, r_valid)
    // no input is taken while a result is blocked
    `ARSM_ASSERT_IMP(a_block, i_clk, i_rst_n, r_valid && !o_out.ready, !in_beat)
endmodule
`default_nettype wire

FILE: tb/aes_round_sub_shift_mix_test.sv
`timescale 1ns / 100ps
`default_nettype none
module aes_round_sub_shift_mix_test;
    import arsm_pkg::*;

    logic i_clk;
    logic i_rst_n;

    arsm_if state_in ();
    arsm_if state_out ();

    aes_round_sub_shift_mix dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (state_in.sink),
        .o_out  (state_out.source)
    );

    localparam int unsigned StallLimit = 2000;
    localparam int unsigned DrainWait  = 10;

    // expected round outputs, oldest first
    t_state round_queue[$];
    int unsigned error_count;
    int unsigned beats_sent;
    int unsigned beats_checked;
    int unsigned idle_cycles;
    int unsigned rx_hold;
    bit          rx_stall_on;

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    // a few long gaps, mostly short or none
    function automatic int unsigned gap_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            return 0;
        end else if (pick < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // byte-level xtime, written independently of the package helper
    function automatic t_byte xtime(input t_byte v);
        return v[7] ? (t_byte'(v << 1) ^ 8'h1b) : t_byte'(v << 1);
    endfunction

    // predict subbytes, shiftrows and mixcolumns for one state
    function automatic t_state round_predict(input t_state s);
        t_byte  sub[4][4];
        t_col   cols_in[4];
        t_col   cols_out[4];
        t_byte  a0, a1, a2, a3;
        t_state res;
        cols_in = '{s.col_0, s.col_1, s.col_2, s.col_3};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sub[r][c] = SBOX[cols_in[c][8*r +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            // row r is taken from column c+r after the rotate
            a0 = sub[0][c];
            a1 = sub[1][(c + 1) % 4];
            a2 = sub[2][(c + 2) % 4];
            a3 = sub[3][(c + 3) % 4];
            cols_out[c][7:0]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            cols_out[c][15:8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            cols_out[c][23:16] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            cols_out[c][31:24] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        res.col_0 = cols_out[0];
        res.col_1 = cols_out[1];
        res.col_2 = cols_out[2];
        res.col_3 = cols_out[3];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input t_col got, input t_col want);
        $display("mismatch beat %0d %s: got %h want %h", beats_checked, what, got, want);
        error_count++;
    endtask

    // drive one state and wait for its beat; valid stays up after the beat
    // so the next call either replaces the data or drops valid for a gap
    task automatic send_state(input t_state s);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            state_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        state_in.valid <= 1'b1;
        state_in.data  <= s;
        @(posedge i_clk);
        while (!state_in.ready) @(posedge i_clk);
        round_queue.push_back(round_predict(s));
        beats_sent++;
    endtask

    // receiver stalls, mostly short with an occasional long one
    always @(posedge i_clk) begin
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (!i_rst_n) begin
            state_out.ready <= 1'b0;
            rx_hold         <= 0;
        end else if (rx_hold != 0) begin
            state_out.ready <= 1'b0;
            rx_hold         <= rx_hold - 1;
        end else if (rx_stall_on) begin
            if (pick < 70) begin
                state_out.ready <= 1'b1;
            end else if (pick < 95) begin
                state_out.ready <= 1'b0;
            end else begin
                state_out.ready <= 1'b0;
                rx_hold         <= $urandom_range(8, 30);
            end
        end else begin
            state_out.ready <= 1'b1;
        end
    end

    // check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_state want;
        if (i_rst_n && state_out.valid && state_out.ready) begin
            if (round_queue.size() == 0) begin
                $display("unexpected result beat %h", state_out.data);
                error_count++;
            end else begin
                want = round_queue.pop_front();
                if (state_out.data.col_0 !== want.col_0)
                    report_mismatch("col_0", state_out.data.col_0, want.col_0);
                if (state_out.data.col_1 !== want.col_1)
                    report_mismatch("col_1", state_out.data.col_1, want.col_1);
                if (state_out.data.col_2 !== want.col_2)
                    report_mismatch("col_2", state_out.data.col_2, want.col_2);
                if (state_out.data.col_3 !== want.col_3)
                    report_mismatch("col_3", state_out.data.col_3, want.col_3);
            end
            beats_checked++;
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((state_in.valid && state_in.ready) || (state_out.valid && state_out.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("aes_round_sub_shift_mix_test: errors");
                $finish;
            end
        end
    end

    function automatic t_state rand_state();
        t_state s;
        s = {$urandom, $urandom, $urandom, $urandom};
        return s;
    endfunction

    // all-zero, all-ones, walking patterns and a known vector
    task automatic test_directed();
        send_state('0);
        send_state('1);
        send_state({4{32'h80808080}});
        send_state({4{32'h01010101}});
        send_state({4{32'h55555555}});
        send_state({4{32'haaaaaaaa}});
        for (int c = 0; c < 4; c++) begin
            send_state(t_state'(128'hff << (32 * c)));
            send_state(t_state'(128'hff000000 << (32 * c)));
        end
        // bytes that carry out of bit 7 after the sbox
        send_state({32'h0f0e0d0c, 32'h0b0a0908, 32'h07060504, 32'h03020100});
        send_state({32'hfffefdfc, 32'hfbfaf9f8, 32'hf7f6f5f4, 32'hf3f2f1f0});
        send_state({32'h8e8d8c8b, 32'h8a898887, 32'h86858483, 32'h82818080});
    endtask

    // every byte value once, each at byte position value mod 16
    task automatic test_sbox_sweep();
        t_state s;
        for (int v = 0; v < 256; v += 16) begin
            for (int k = 0; k < 16; k++) s[8*k +: 8] = t_byte'(v + k);
            send_state(s);
        end
    endtask

    task automatic test_random(input int unsigned count);
        for (int unsigned n = 0; n < count; n++) send_state(rand_state());
    endtask

    task automatic drain();
        state_in.valid <= 1'b0;
        while (round_queue.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    initial begin
        error_count    = 0;
        beats_sent     = 0;
        beats_checked  = 0;
        idle_cycles    = 0;
        rx_stall_on    = 1'b0;
        i_rst_n        = 1'b0;
        state_in.valid = 1'b0;
        state_in.data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_sbox_sweep();
        rx_stall_on = 1'b1;
        test_random(250);
        rx_stall_on = 1'b0;
        test_random(120);
        drain();

        $display("sent %0d states (directed, full sbox sweep, random), checked %0d results",
                 beats_sent, beats_checked);
        if (error_count == 0) begin
            $display("aes_round_sub_shift_mix_test: clean");
        end else begin
            $display("aes_round_sub_shift_mix_test: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
